[rtl/mbps_pkg.sv]
// ----------------------------------------------------------------------------
// mbps_pkg
// Shared constants and types for the masked byte pattern search block.
// ----------------------------------------------------------------------------
package mbps_pkg;

  localparam int PATTERN_MAX_DEF  = 32;
  localparam int OFFSET_WIDTH_DEF = 32;

  localparam int PAT_WORDS  = 4;
  localparam int WORD_W     = 64;
  localparam int PAT_BYTES  = 32;
  localparam int PLEN_W     = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_WORD3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAT_LEN   = 3'd5;

  localparam logic [PAT_BYTES-1:0] CARE_RESET = '1;
  localparam logic [PLEN_W-1:0]    PLEN_RESET = 6'd1;

  typedef struct packed {
    logic [PAT_WORDS-1:0][WORD_W-1:0] pat_words;
    logic [PAT_BYTES-1:0]             care;
    logic [PLEN_W-1:0]                plen;
  } cfg_t;

endpackage

[rtl/mbps_chan_if.sv]
// ----------------------------------------------------------------------------
// mbps_chan_if
// Valid/ready channels: scanned byte requests in, search results out.
// ----------------------------------------------------------------------------
interface mbps_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface mbps_out_if #(
  parameter int OFFSET_WIDTH = 32
);
  logic                    valid;
  logic                    ready;
  logic                    found;
  logic [OFFSET_WIDTH-1:0] match_offset;

  modport source (output valid, output found, output match_offset, input ready);
  modport sink   (input valid, input found, input match_offset, output ready);
endinterface

[rtl/mbps_match.sv]
// ----------------------------------------------------------------------------
// mbps_match
// Parallel masked compare of the byte window against the pattern.
// ----------------------------------------------------------------------------
module mbps_match
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX = PATTERN_MAX_DEF,
  parameter int LEN_W       = $clog2(PATTERN_MAX + 1)
) (
  input  logic [PATTERN_MAX-1:0][7:0] window_i,  // index 0 is newest
  input  logic [LEN_W-1:0]            len_i,
  input  cfg_t                        cfg_i,
  output logic                        match_o
);

  logic [PAT_BYTES-1:0][7:0] pat_bytes;

  assign pat_bytes = cfg_i.pat_words;

  // window byte k lines up with pattern byte len-1-k
  always_comb begin
    logic [LEN_W+4:0] j;
    match_o = 1'b1;
    for (int k = 0; k < PATTERN_MAX; k++) begin
      j = (LEN_W + 5)'(len_i) - (LEN_W + 5)'(k + 1);
      if ((LEN_W + 5)'(k) < (LEN_W + 5)'(len_i) && j < (LEN_W + 5)'(PAT_BYTES)) begin
        if (cfg_i.care[j[4:0]] && pat_bytes[j[4:0]] != window_i[k]) begin
          match_o = 1'b0;
        end
      end
    end
  end

endmodule

[rtl/masked_byte_pattern_search_top.sv]
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_top
// Streams region bytes and reports the first offset of a masked pattern or a miss.
// Result: the result register loads at the edge a byte is accepted.
// Throughput: one byte per cycle outside stalls; the window compare is one registered pass.
// Stall: the result register is held while a result waits and a new request
//   is still taken when that result leaves in the same cycle.
// Reset: config returns to zero pattern, full care mask, length 1; counter
//   and match flag clear, result register empty.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_top
  import mbps_pkg::*;
#(
  parameter int PATTERN_MAX  = PATTERN_MAX_DEF,
  parameter int OFFSET_WIDTH = OFFSET_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  mbps_in_if.sink               in_i,
  mbps_out_if.source            out_o
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int CNT_W = OFFSET_WIDTH + 1;
  localparam int SAT_W = PLEN_W + 2;

  cfg_t cfg_q;

  logic [PATTERN_MAX-1:0][7:0] window_q, window_d;
  logic [CNT_W-1:0]            cnt_q, cnt_d, cnt_inc;
  logic                        reported_q, reported_d;

  logic                    out_valid_q, out_valid_d;
  logic                    found_q, found_d;
  logic [OFFSET_WIDTH-1:0] offset_q, offset_d;

  logic [LEN_W-1:0] len;
  logic [CNT_W-1:0] off_full;
  logic             win_match, hit, accept;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pat_words <= '0;
      cfg_q.care      <= CARE_RESET;
      cfg_q.plen      <= PLEN_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PAT_WORD0: cfg_q.pat_words[0] <= cfg_wdata_i;
        CFG_PAT_WORD1: cfg_q.pat_words[1] <= cfg_wdata_i;
        CFG_PAT_WORD2: cfg_q.pat_words[2] <= cfg_wdata_i;
        CFG_PAT_WORD3: cfg_q.pat_words[3] <= cfg_wdata_i;
        CFG_CARE_MASK: cfg_q.care         <= cfg_wdata_i[PAT_BYTES-1:0];
        CFG_PAT_LEN:   cfg_q.plen         <= cfg_wdata_i[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // length clamped to the window depth
  assign len = (SAT_W'(cfg_q.plen) > SAT_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX)
                                                           : LEN_W'(cfg_q.plen);

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // new byte enters at index 0, oldest byte drops out
  assign window_d = (8 * PATTERN_MAX)'({window_q, in_i.data_byte});

  assign cnt_inc = (&cnt_q) ? cnt_q : cnt_q + CNT_W'(1);

  mbps_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .LEN_W       (LEN_W)
  ) u_match (
    .window_i (window_d),
    .len_i    (len),
    .cfg_i    (cfg_q),
    .match_o  (win_match)
  );

  assign hit = !reported_q && (len != '0) && (cnt_inc >= CNT_W'(len)) && win_match;
  assign off_full = cnt_inc - CNT_W'(len);

  always_comb begin
    cnt_d       = cnt_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && !out_o.ready;
    found_d     = found_q;
    offset_d    = offset_q;
    if (accept) begin
      cnt_d      = cnt_inc;
      reported_d = reported_q || hit;
      if (hit) begin
        out_valid_d = 1'b1;
        found_d     = 1'b1;
        offset_d    = off_full[OFFSET_WIDTH] ? '1 : off_full[OFFSET_WIDTH-1:0];
      end else if (in_i.last_byte && !reported_q) begin
        out_valid_d = 1'b1;
        found_d     = 1'b0;
        offset_d    = '0;
      end
      if (in_i.last_byte) begin
        cnt_d      = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload: window bytes older than the region are never compared
  always_ff @(posedge clk_i) begin
    if (accept) begin
      window_q <= window_d;
    end
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.found        = found_q;
  assign out_o.match_offset = offset_q;

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for masked_byte_pattern_search_top. Scanned byte requests are
// predicted by a scoreboard that keeps its own byte window, region counter
// and register copy. Each result is checked in order against it. A short
// directed part comes first, then random regions under random register
// settings, with bursty requests, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mbps_pkg::*;

  localparam int OFF_W = OFFSET_WIDTH_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;
  localparam int SETTLE_CYCLES  = 4;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RANDOM_PHASES  = 12;
  localparam int PHASE_BYTES    = 85;

  typedef struct packed {
    logic             found;
    logic [OFF_W-1:0] offset;
  } scan_result_t;

  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  class scan_scoreboard;
    logic [WORD_W-1:0]    pat_words [PAT_WORDS];
    logic [PAT_BYTES-1:0] care;
    logic [PLEN_W-1:0]    plen;
    logic [7:0]           recent [PATTERN_MAX_DEF];  // [0] is newest
    logic [OFF_W:0]       seen_cnt;
    bit                   hit_done;
    scan_result_t         hits_due [$];
    int                   errors;

    function new();
      foreach (pat_words[w]) pat_words[w] = '0;
      care     = CARE_RESET;
      plen     = PLEN_RESET;
      errors   = 0;
      clear_region();
    endfunction

    function void clear_region();
      foreach (recent[i]) recent[i] = 8'h00;
      seen_cnt = '0;
      hit_done = 1'b0;
    endfunction

    function logic [7:0] pat_byte(int j);
      return pat_words[j / 8][8 * (j % 8) +: 8];
    endfunction

    function int eff_len();
      return (plen > PATTERN_MAX_DEF) ? PATTERN_MAX_DEF : int'(plen);
    endfunction

    function int pending();
      return hits_due.size();
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_PAT_WORD0: pat_words[0] = val;
        CFG_PAT_WORD1: pat_words[1] = val;
        CFG_PAT_WORD2: pat_words[2] = val;
        CFG_PAT_WORD3: pat_words[3] = val;
        CFG_CARE_MASK: care = val[PAT_BYTES-1:0];
        CFG_PAT_LEN:   plen = val[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] d, logic l);
      int           span;
      bit           hit;
      logic [OFF_W:0] off;
      scan_result_t r;
      span = eff_len();
      for (int i = PATTERN_MAX_DEF - 1; i > 0; i--) recent[i] = recent[i-1];
      recent[0] = d;
      if (seen_cnt != '1) seen_cnt++;
      if (!hit_done && span != 0 && seen_cnt >= span) begin
        hit = 1'b1;
        // oldest byte of the window lines up with pattern byte 0
        for (int j = 0; j < span; j++)
          if (care[j] && pat_byte(j) != recent[span-1-j]) hit = 1'b0;
        if (hit) begin
          off      = seen_cnt - span;
          r.found  = 1'b1;
          r.offset = off[OFF_W] ? '1 : off[OFF_W-1:0];
          hits_due = {hits_due, r};
          hit_done = 1'b1;
        end
      end
      if (l) begin
        if (!hit_done) begin
          r.found  = 1'b0;
          r.offset = '0;
          hits_due = {hits_due, r};
        end
        clear_region();
      end
    endfunction

    function void miss(string field, logic [OFF_W-1:0] want, logic [OFF_W-1:0] got);
      errors++;
      $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
    endfunction

    function void check_result(logic f, logic [OFF_W-1:0] off);
      scan_result_t want;
      if (hits_due.size() == 0) begin
        errors++;
        $error("result with none pending: found=%0b match_offset=0x%0h", f, off);
        return;
      end
      want = hits_due.pop_front();
      if (f !== want.found) miss("found", want.found, f);
      if (off !== want.offset) miss("match_offset", want.offset, off);
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mbps_in_if                         in_if ();
  mbps_out_if #(.OFFSET_WIDTH(OFF_W)) out_if ();

  masked_byte_pattern_search_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  scan_scoreboard sb = new();
  int burst_left  = 0;
  int hold_reqs   = 0;
  int quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  // Monitor and watchdog: values read here are the ones before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready)
        sb.check_result(out_if.found, out_if.match_offset);
      if (in_if.valid && in_if.ready)
        sb.note_byte(in_if.data_byte, in_if.last_byte);
      if ((out_if.valid && out_if.ready) || (in_if.valid && in_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  // Receiver: stall pattern changes now and then; a hold-off request wins.
  initial begin : rx_side
    int       hold_cnt;
    int       hold_seen;
    int       mode_left;
    rx_mode_e mode;
    hold_cnt     = 0;
    hold_seen    = 0;
    mode_left    = 0;
    mode         = RX_OPEN;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_cnt == 0 && hold_seen != hold_reqs) begin
        hold_seen++;
        hold_cnt = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_e'($urandom_range(0, 3));
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_if.ready <= 1'b0;
      end else begin
        case (mode)
          RX_OPEN:   out_if.ready <= 1'b1;
          RX_COIN:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_SPARSE: out_if.ready <= ($urandom_range(0, 3) == 0);
          default:   out_if.ready <= (mode_left % 6 != 0);
        endcase
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_byte(input logic [7:0] d, input logic l);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                : $urandom_range(1, 12);
    end
    burst_left--;
    in_if.valid     <= 1'b1;
    in_if.data_byte <= d;
    in_if.last_byte <= l;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    // a byte with no result may still sit in the pipeline
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    sb.write_reg(idx, val);
    @(negedge clk_i);
  endtask

  // Upper bits of the narrow registers carry junk that must be dropped.
  task automatic apply_setting(input logic [PAT_WORDS-1:0][WORD_W-1:0] words,
                               input logic [PAT_BYTES-1:0] care,
                               input logic [PLEN_W-1:0] plen);
    put_reg(CFG_PAT_WORD0, words[0]);
    put_reg(CFG_PAT_WORD1, words[1]);
    put_reg(CFG_PAT_WORD2, words[2]);
    put_reg(CFG_PAT_WORD3, words[3]);
    put_reg(CFG_CARE_MASK, {32'($urandom), care});
    put_reg(CFG_PAT_LEN, {32'($urandom), 26'($urandom), plen});
    if ($urandom_range(0, 2) == 0)
      put_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B, {$urandom, $urandom});
    cfg_we <= 1'b0;
  endtask

  task automatic run_region(input int len, input bit embed);
    logic [7:0] region_bytes [$];
    int         span;
    int         pos;
    span = sb.eff_len();
    // filler mixes fully random bytes with pattern bytes for near misses
    for (int k = 0; k < len; k++)
      region_bytes = {region_bytes, ($urandom_range(0, 1) ? 8'($urandom)
                      : sb.pat_byte($urandom_range(0, PAT_BYTES - 1)))};
    if (embed && span > 0 && len >= span) begin
      pos = $urandom_range(0, len - span);
      for (int j = 0; j < span; j++)
        if (sb.care[j]) region_bytes[pos+j] = sb.pat_byte(j);
    end
    foreach (region_bytes[k]) send_byte(region_bytes[k], k == len - 1);
  endtask

  initial begin
    logic [PAT_WORDS-1:0][WORD_W-1:0] words;
    logic [PAT_BYTES-1:0]             care;
    logic [PLEN_W-1:0]                plen;
    int                               sent;
    int                               len;
    int                               span;

    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    in_if.valid     = 1'b0;
    in_if.data_byte = '0;
    in_if.last_byte = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // reset settings: one-byte pattern 0x00
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // bytes after the match are only counted
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // settings changed in the middle of a region
    apply_setting(256'h77, '1, 6'd1);
    send_byte(8'h10, 1'b0);
    drain();
    apply_setting(256'h2010, '1, 6'd2);
    send_byte(8'h20, 1'b1);
    drain();

    // region shorter than the pattern
    apply_setting(256'hDDCC_BBAA, '1, 6'd4);
    send_byte(8'hAA, 1'b0);
    send_byte(8'hBB, 1'b0);
    send_byte(8'hCC, 1'b1);
    drain();

    // zero length never matches
    apply_setting({8{$urandom}}, '1, 6'd0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    drain();

    // all wildcards
    apply_setting({8{$urandom}}, '0, 6'd3);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h5A, 1'b1);
    drain();

    // leading wildcard, match at offset 1
    apply_setting(256'hFF00, 32'h2, 6'd2);
    send_byte(8'h00, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b1);
    drain();

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 5))
        0:       words = '0;
        1:       words = '1;
        default: words = {$urandom, $urandom, $urandom, $urandom,
                          $urandom, $urandom, $urandom, $urandom};
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: plen = 6'($urandom_range(1, 6));
        5:             plen = 6'd32;
        6:             plen = 6'($urandom_range(7, 31));
        7:             plen = 6'd0;
        8:             plen = 6'($urandom_range(33, 63));
        default:       plen = 6'd1;
      endcase
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: care = '1;
        6, 7:             care = $urandom;
        8:                care = $urandom & $urandom;
        default:          care = '0;
      endcase
      if (ph == 0) begin
        plen = 6'd32;
        care = '1;
      end else if (ph == 1) begin
        plen = 6'd63;
      end
      apply_setting(words, care, plen);
      // long receiver hold-off while requests keep coming
      if (ph == 2) hold_reqs++;
      sent = 0;
      while (sent < PHASE_BYTES) begin
        span = sb.eff_len();
        len  = (span == 0) ? $urandom_range(1, 8) : $urandom_range(1, span + 10);
        run_region(len, $urandom_range(0, 9) < 7);
        sent += len;
      end
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
